### design/qrs_pkg.sv
// qrs_pkg: shared types, widths and helper steps for the quadratic root solver
// used by qrs_front, qrs_sqrt, qrs_div and quadratic_root_solver_core
package qrs_pkg;

   localparam int CoefW   = 16;
   localparam int DiscW   = 34;
   localparam int MagW    = 33;
   localparam int RadW    = 64;
   localparam int RemW    = 36;
   localparam int RootW   = 32;
   localparam int SqStages = 16;
   localparam int NumW    = 34;
   localparam int DenW    = 16;
   localparam int DivStages = 17;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_QUAD = 2'd1;
   localparam logic [1:0] ST_NEG_DISC = 2'd2;

   typedef struct packed {
      logic signed [CoefW-1:0] coef_a;
      logic signed [CoefW-1:0] coef_b;
      logic signed [CoefW-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic signed [31:0] root_plus;
      logic signed [31:0] root_minus;
      logic               has_roots;
      logic [1:0]         status;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [CoefW-1:0] a;
      logic signed [CoefW-1:0] b;
   } ctl_type;

   typedef struct packed {
      logic [RadW-1:0]  rad;
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
   } sq_type;

   typedef struct packed {
      logic [NumW-1:0] num;
      logic [DenW-1:0] rem;
   } dv_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [DenW-1:0] den;
      logic            neg_p;
      logic            neg_m;
   } dctl_type;

   function automatic sq_type sqrt_step(input sq_type x);
      sq_type          y;
      logic [RemW-1:0] r;
      logic [RemW-1:0] trial;
      r     = {x.rem[RemW-3:0], x.rad[RadW-1 -: 2]};
      trial = {2'b00, x.root, 2'b01};
      y.rad = {x.rad[RadW-3:0], 2'b00};
      if (r >= trial) begin
         y.rem  = r - trial;
         y.root = {x.root[RootW-2:0], 1'b1};
      end else begin
         y.rem  = r;
         y.root = {x.root[RootW-2:0], 1'b0};
      end
      return y;
   endfunction

   function automatic dv_type div_step(input dv_type x, input logic [DenW-1:0] den);
      dv_type        y;
      logic [DenW:0] r;
      r     = {x.rem, x.num[NumW-1]};
      y.num = {x.num[NumW-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
         r        = r - {1'b0, den};
         y.num[0] = 1'b1;
      end
      y.rem = r[DenW-1:0];
      return y;
   endfunction

endpackage

### design/qrs_front.sv
// qrs_front: coefficient products and discriminant, two register stages
// depends on qrs_pkg
module qrs_front
   import qrs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  req_type         in_req,
   output logic            out_valid,
   output logic [MagW-1:0] out_disc,
   output ctl_type         out_ctl
);

   logic                    v1_ff;
   req_type                 req_ff;
   logic signed [31:0]      bb_ff;
   logic signed [31:0]      ac_ff;
   logic                    v2_ff;
   logic [MagW-1:0]         disc_ff;
   ctl_type                 ctl_ff;
   logic signed [DiscW-1:0] disc_in;
   ctl_type                 ctl_in;

   always_comb begin
      disc_in = DiscW'(bb_ff) - (DiscW'(ac_ff) <<< 2);
      ctl_in.a = req_ff.coef_a;
      ctl_in.b = req_ff.coef_b;
      if (req_ff.coef_a == '0) begin
         ctl_in.status = ST_NOT_QUAD;
      end else if (disc_in < 0) begin
         ctl_in.status = ST_NEG_DISC;
      end else begin
         ctl_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= in_req;
      bb_ff   <= 32'(in_req.coef_b) * 32'(in_req.coef_b);
      ac_ff   <= 32'(in_req.coef_a) * 32'(in_req.coef_c);
      ctl_ff  <= ctl_in;
      disc_ff <= (ctl_in.status == ST_OK) ? disc_in[MagW-1:0] : '0;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_disc  = disc_ff;
   assign out_ctl   = ctl_ff;

endmodule

### design/qrs_sqrt.sv
// qrs_sqrt: pipelined integer square root of disc * 2^30, two result bits per stage
// depends on qrs_pkg
module qrs_sqrt
   import qrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [MagW-1:0]  in_disc,
   input  ctl_type          in_ctl,
   output logic             out_valid,
   output logic [RootW-1:0] out_root,
   output ctl_type          out_ctl
);

   sq_type  sq_ff  [0:SqStages-1];
   ctl_type ctl_ff [0:SqStages-1];
   logic    vld_ff [0:SqStages-1];
   sq_type  sq_src [0:SqStages-1];
   ctl_type ctl_src[0:SqStages-1];
   logic    vld_src[0:SqStages-1];

   assign sq_src[0]  = '{rad: {1'b0, in_disc, 30'b0}, rem: '0, root: '0};
   assign ctl_src[0] = in_ctl;
   assign vld_src[0] = in_valid;

   for (genvar i = 0; i < SqStages; i++) begin : g_stage
      if (i > 0) begin : g_link
         assign sq_src[i]  = sq_ff[i-1];
         assign ctl_src[i] = ctl_ff[i-1];
         assign vld_src[i] = vld_ff[i-1];
      end
      always_ff @(posedge clock) begin
         sq_ff[i]  <= sqrt_step(sqrt_step(sq_src[i]));
         ctl_ff[i] <= ctl_src[i];
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_src[i];
         end
      end
   end

   assign out_valid = vld_ff[SqStages-1];
   assign out_root  = sq_ff[SqStages-1].root;
   assign out_ctl   = ctl_ff[SqStages-1];

endmodule

### design/qrs_div.sv
// qrs_div: numerator forming and two pipelined restoring dividers, two bits per stage
// depends on qrs_pkg
module qrs_div
   import qrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [RootW-1:0] in_root,
   input  ctl_type          in_ctl,
   output logic             out_valid,
   output logic [NumW-1:0]  out_qp,
   output logic [NumW-1:0]  out_qm,
   output dctl_type         out_ctl
);

   logic signed [NumW:0] nb;
   logic signed [NumW:0] np;
   logic signed [NumW:0] nm;
   logic signed [NumW:0] np_abs;
   logic signed [NumW:0] nm_abs;
   logic signed [CoefW:0] a_ext;
   logic signed [CoefW:0] a_abs;
   dctl_type             pctl_in;

   logic     pv_ff;
   dv_type   pp_ff;
   dv_type   pm_ff;
   dctl_type pctl_ff;

   dv_type   dp_ff  [0:DivStages-1];
   dv_type   dm_ff  [0:DivStages-1];
   dctl_type dc_ff  [0:DivStages-1];
   logic     dvv_ff [0:DivStages-1];
   dv_type   dp_src [0:DivStages-1];
   dv_type   dm_src [0:DivStages-1];
   dctl_type dc_src [0:DivStages-1];
   logic     dvv_src[0:DivStages-1];

   always_comb begin
      nb     = -((NumW+1)'(in_ctl.b) <<< 15);
      np     = nb + (NumW+1)'(in_root);
      nm     = nb - (NumW+1)'(in_root);
      np_abs = (np < 0) ? -np : np;
      nm_abs = (nm < 0) ? -nm : nm;
      a_ext  = (CoefW+1)'(in_ctl.a);
      a_abs  = (a_ext < 0) ? -a_ext : a_ext;
      pctl_in.status = in_ctl.status;
      pctl_in.den    = a_abs[DenW-1:0];
      pctl_in.neg_p  = (np < 0) ^ (a_ext < 0);
      pctl_in.neg_m  = (nm < 0) ^ (a_ext < 0);
   end

   always_ff @(posedge clock) begin
      pp_ff   <= '{num: np_abs[NumW-1:0], rem: '0};
      pm_ff   <= '{num: nm_abs[NumW-1:0], rem: '0};
      pctl_ff <= pctl_in;
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= in_valid;
      end
   end

   assign dp_src[0]  = pp_ff;
   assign dm_src[0]  = pm_ff;
   assign dc_src[0]  = pctl_ff;
   assign dvv_src[0] = pv_ff;

   for (genvar i = 0; i < DivStages; i++) begin : g_stage
      if (i > 0) begin : g_link
         assign dp_src[i]  = dp_ff[i-1];
         assign dm_src[i]  = dm_ff[i-1];
         assign dc_src[i]  = dc_ff[i-1];
         assign dvv_src[i] = dvv_ff[i-1];
      end
      always_ff @(posedge clock) begin
         dp_ff[i] <= div_step(div_step(dp_src[i], dc_src[i].den), dc_src[i].den);
         dm_ff[i] <= div_step(div_step(dm_src[i], dc_src[i].den), dc_src[i].den);
         dc_ff[i] <= dc_src[i];
         if (reset) begin
            dvv_ff[i] <= 1'b0;
         end else begin
            dvv_ff[i] <= dvv_src[i];
         end
      end
   end

   assign out_valid = dvv_ff[DivStages-1];
   assign out_qp    = dp_ff[DivStages-1].num;
   assign out_qm    = dm_ff[DivStages-1].num;
   assign out_ctl   = dc_ff[DivStages-1];

endmodule

### design/quadratic_root_solver_core.sv
// quadratic_root_solver_core: real roots of a*x^2+b*x+c, Q8.8 in, Q16.16 out
// results pass through qrs_front, the 16-stage square root, the numerator
// register, the 17-stage dividers and an output register; one item accepted every cycle, busy stays low
// synchronous reset clears only the valid bits; the receiver cannot stall
// depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_div
module quadratic_root_solver_core
   import qrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   logic             f_valid;
   logic [MagW-1:0]  f_disc;
   ctl_type          f_ctl;
   logic             s_valid;
   logic [RootW-1:0] s_root;
   ctl_type          s_ctl;
   logic             d_valid;
   logic [NumW-1:0]  d_qp;
   logic [NumW-1:0]  d_qm;
   dctl_type         d_ctl;

   logic signed [NumW:0] vp;
   logic signed [NumW:0] vm;
   logic                 sat_p;
   logic                 sat_m;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   localparam logic signed [NumW:0] QMax = (NumW+1)'(64'sd2147483647);
   localparam logic signed [NumW:0] QMin = (NumW+1)'(-64'sd2147483648);

   assign busy = 1'b0;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_req    (req_item),
      .out_valid (f_valid),
      .out_disc  (f_disc),
      .out_ctl   (f_ctl)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_disc   (f_disc),
      .in_ctl    (f_ctl),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_ctl   (s_ctl)
   );

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_ctl    (s_ctl),
      .out_valid (d_valid),
      .out_qp    (d_qp),
      .out_qm    (d_qm),
      .out_ctl   (d_ctl)
   );

   always_comb begin
      vp    = d_ctl.neg_p ? -(NumW+1)'(d_qp) : (NumW+1)'(d_qp);
      vm    = d_ctl.neg_m ? -(NumW+1)'(d_qm) : (NumW+1)'(d_qm);
      sat_p = (vp > QMax) || (vp < QMin);
      sat_m = (vm > QMax) || (vm < QMin);
      rsp_in.status = d_ctl.status;
      if (d_ctl.status == ST_OK) begin
         rsp_in.root_plus  = (vp > QMax) ? QMax[31:0] : ((vp < QMin) ? QMin[31:0] : vp[31:0]);
         rsp_in.root_minus = (vm > QMax) ? QMax[31:0] : ((vm < QMin) ? QMin[31:0] : vm[31:0]);
         rsp_in.has_roots  = 1'b1;
         rsp_in.saturated  = sat_p | sat_m;
      end else begin
         rsp_in.root_plus  = '0;
         rsp_in.root_minus = '0;
         rsp_in.has_roots  = 1'b0;
         rsp_in.saturated  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### verif/tb_quadratic_root_solver_core.sv
// testbench for quadratic_root_solver_core: directed and random coefficient sets,
// each result checked against an in-bench fixed-point root predictor
// depends on qrs_pkg and the quadratic_root_solver_core rtl
module tb_quadratic_root_solver_core;
   import qrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   rsp_type expected_roots[$];
   int      fail_count = 0;
   int      cycle_count = 0;

   quadratic_root_solver_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAIL quadratic_root_solver_core");
         $finish;
      end
   end

   function automatic logic [63:0] scaled_isqrt(input logic [63:0] disc);
      logic [127:0] rad;
      logic [63:0]  root;
      logic [127:0] rem;
      logic [127:0] trial;
      rad  = {64'd0, disc} << 30;
      root = '0;
      rem  = '0;
      for (int i = 46; i >= 0; i--) begin
         rem   = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
         trial = ({64'd0, root} << 2) | 128'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic signed [31:0] clip_q16(input logic signed [63:0] q,
                                                   inout logic sat);
      if (q > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (q < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return q[31:0];
   endfunction

   function automatic rsp_type solve_roots(input req_type r);
      rsp_type           y;
      logic signed [63:0] a, b, c, disc, s, nb;
      logic               sat;
      a   = r.coef_a;
      b   = r.coef_b;
      c   = r.coef_c;
      sat = 1'b0;
      y   = '0;
      if (a == 0) begin
         y.status = ST_NOT_QUAD;
         return y;
      end
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
         y.status = ST_NEG_DISC;
         return y;
      end
      s  = scaled_isqrt(disc);
      nb = -b * 64'sd32768;
      y.root_plus  = clip_q16((nb + s) / a, sat);
      y.root_minus = clip_q16((nb - s) / a, sat);
      y.has_roots  = 1'b1;
      y.status     = ST_OK;
      y.saturated  = sat;
      return y;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_roots.size() == 0) begin
            $error("result with no item pending");
            fail_count++;
         end else begin
            e = expected_roots.pop_front();
            if (rsp_item.root_plus !== e.root_plus) begin
               $error("root_plus exp %0d got %0d", e.root_plus, rsp_item.root_plus);
               fail_count++;
            end
            if (rsp_item.root_minus !== e.root_minus) begin
               $error("root_minus exp %0d got %0d", e.root_minus, rsp_item.root_minus);
               fail_count++;
            end
            if (rsp_item.has_roots !== e.has_roots) begin
               $error("has_roots exp %0d got %0d", e.has_roots, rsp_item.has_roots);
               fail_count++;
            end
            if (rsp_item.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_item.status);
               fail_count++;
            end
            if (rsp_item.saturated !== e.saturated) begin
               $error("saturated exp %0d got %0d", e.saturated, rsp_item.saturated);
               fail_count++;
            end
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // start stays high across back-to-back items
   task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input bit gaps);
      req_type r;
      r.coef_a = a;
      r.coef_b = b;
      r.coef_c = c;
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_roots.push_back(solve_roots(r));
      @(negedge clock);
      if (gaps && ($urandom_range(0, 1) != 0)) begin
         idle_gap();
      end
   endtask

   task automatic test_directed();
      send_coefs(16'h0000, 16'h1234, 16'h0100, 1'b0);
      send_coefs(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_coefs(16'h0100, 16'h0000, 16'h0100, 1'b0);
      send_coefs(16'h0100, 16'h0200, 16'h0100, 1'b0);
      send_coefs(16'h0100, 16'h0000, 16'hff00, 1'b0);
      send_coefs(16'h0100, 16'hfd00, 16'h0200, 1'b0);
      send_coefs(16'h7fff, 16'h7fff, 16'h8000, 1'b0);
      send_coefs(16'h8000, 16'h8000, 16'h7fff, 1'b0);
      send_coefs(16'h8000, 16'h7fff, 16'h7fff, 1'b0);
      send_coefs(16'h0001, 16'h7fff, 16'h0000, 1'b0);
      send_coefs(16'h0001, 16'h8000, 16'h0000, 1'b0);
      send_coefs(16'hffff, 16'h8000, 16'h8000, 1'b0);
      send_coefs(16'h0001, 16'h0000, 16'h8000, 1'b0);
      send_coefs(16'hffff, 16'h0000, 16'h7fff, 1'b0);
      send_coefs(16'h7fff, 16'h0000, 16'h0000, 1'b0);
      send_coefs(16'hffff, 16'hffff, 16'hffff, 1'b0);
      send_coefs(16'h0100, 16'h0100, 16'h0100, 1'b0);
      send_coefs(16'h0002, 16'h0004, 16'h0002, 1'b0);
   endtask

   task automatic test_random();
      logic [15:0] a, b, c;
      for (int i = 0; i < 1630; i++) begin
         a = 16'($urandom());
         b = 16'($urandom());
         c = 16'($urandom());
         case ($urandom_range(0, 5))
            0: a = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom_range(0, 7));
            1: c = -$signed(c) ^ {16{a[15]}};
            2: begin
               a = 16'($urandom_range(1, 255));
               b = 16'($urandom());
            end
            3: b = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
            default: ;
         endcase
         send_coefs(a, b, c, i > 100);
      end
      start <= 1'b0;
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      waited = 0;
      while (expected_roots.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0 && expected_roots.size() == 0) begin
         $display("PASS quadratic_root_solver_core");
      end else begin
         $display("FAIL quadratic_root_solver_core");
      end
      $finish;
   end
endmodule
